// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define SETQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SETQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/setq_pkg.sv
// ----------------------------------------------------------------------------
// setq_pkg
// sizes, codes and types shared by the sorted timer queue
// ----------------------------------------------------------------------------
package setq_pkg;

	localparam int ENTRIES     = 16;
	localparam int TIME_BITS   = 32;
	localparam int MAX_RESULTS = 16;

	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int TICK_LIMIT = (MAX_RESULTS < ENTRIES) ? MAX_RESULTS : ENTRIES;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_ADJUST = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EXPIRED  = 3'd1;
	localparam logic [2:0] ST_NONE     = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [15:0]          handle_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef struct packed {
		handle_t handle;
		time_t   expiry;
	} entry_t;

	// one write and one read port of the entry store
	typedef struct packed {
		logic   wr_en;
		idx_t   wr_addr;
		entry_t wr_data;
		logic   rd_en;
		idx_t   rd_addr;
	} mem_req_t;

endpackage

// File: rtl/setq_if.sv
// ----------------------------------------------------------------------------
// setq channel interfaces
// command channel into the queue and result channel out of it
// ----------------------------------------------------------------------------
interface setq_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] handle;
	logic [31:0] time_value;

	modport source (output valid, command, handle, time_value, input ready);
	modport sink (input valid, command, handle, time_value, output ready);
endinterface

interface setq_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] handle_res;
	logic [2:0]  status;
	logic        last;

	modport source (output valid, handle_res, status, last, input ready);
	modport sink (input valid, handle_res, status, last, output ready);
endinterface

// File: rtl/setq_mem.sv
// ----------------------------------------------------------------------------
// setq_mem
// entry store in queue order, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module setq_mem (
	input  logic               clk,
	input  setq_pkg::mem_req_t mreq,
	output setq_pkg::entry_t   rd_data
);
	import setq_pkg::*;

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr] <= mreq.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.rd_en) begin
			rd_data <= mem[mreq.rd_addr];
		end
	end

endmodule

// File: rtl/sorted_expiry_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue
// add: walks from the back to the slot, moving each later expiry back one slot
// delete: walks the whole queue; adjust: a delete walk then an insert walk
// tick: walks from the front, expiring and then compacting, and closes when the walk
//   reaches the tail or stops at an unexpired front; each entry visit costs an address
//   step and a compare/move step on the single store
// one request at a time; the next one is taken while a result still waits
// reset clears the count and the sequencer at once, the store needs no sweep
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_expiry_timer_queue (
	input  logic       clk,
	input  logic       arst_n,
	setq_cmd_if.sink   req,
	setq_res_if.source rsp
);
	import setq_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_INS_RD = 4'd1;
	localparam logic [3:0] S_INS_EV = 4'd2;
	localparam logic [3:0] S_DEL_RD = 4'd3;
	localparam logic [3:0] S_DEL_EV = 4'd4;
	localparam logic [3:0] S_TK_RD  = 4'd5;
	localparam logic [3:0] S_TK_EV  = 4'd6;
	localparam logic [3:0] S_TK_END = 4'd7;
	localparam logic [3:0] S_RESP   = 4'd8;

	logic [3:0] state_q;
	cnt_t       cnt_q;      // valid entries, in slots 0 .. cnt_q-1
	cnt_t       idx_q;      // walk position (insert: the open slot)
	cnt_t       k_q;        // entries expired by the current tick
	logic       found_q;    // delete walk has passed the matching entry
	logic       pend_q;     // an expired handle waits for its last flag
	logic       exp_done_q; // tick has stopped expiring, now compacting
	handle_t    pend_h_q;
	logic [1:0] cmd_q;
	handle_t    h_q;
	time_t      t_q;
	logic [2:0] status_q;

	logic       out_valid_q;
	handle_t    out_h_q;
	logic [2:0] out_st_q;
	logic       out_last_q;

	mem_req_t   mreq;
	entry_t     rdata;
	entry_t     new_entry;
	cnt_t       idx_m1;
	logic       out_free;
	logic       tk_expired;
	logic       push;
	handle_t    push_h;
	logic [2:0] push_st;
	logic       push_last;

	setq_mem u_mem (
		.clk     (clk),
		.mreq    (mreq),
		.rd_data (rdata)
	);

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid      = out_valid_q;
	assign rsp.handle_res = out_h_q;
	assign rsp.status     = out_st_q;
	assign rsp.last       = out_last_q;

	assign new_entry  = '{handle: h_q, expiry: t_q};
	assign idx_m1     = idx_q - cnt_t'(1);
	assign out_free   = !out_valid_q || rsp.ready;
	// read entry expires if due by t_q, while still expiring and under the per-tick limit
	assign tk_expired = !exp_done_q && (k_q != cnt_t'(TICK_LIMIT)) &&
		(rdata.expiry <= t_q);

	// store accesses and result pushes
	always_comb begin
		mreq      = '0;
		push      = 1'b0;
		push_h    = '0;
		push_st   = ST_OK;
		push_last = 1'b1;
		unique case (state_q)
			S_INS_RD: begin
				if (idx_q == '0) begin
					// reached the front: the new timer goes in slot 0
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = '0;
					mreq.wr_data = new_entry;
				end else begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = idx_m1[IDX_W-1:0];
				end
			end
			S_INS_EV: begin
				// later expiries move back one slot, else the new timer fills the hole
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = idx_q[IDX_W-1:0];
				mreq.wr_data = (rdata.expiry > t_q) ? rdata : new_entry;
			end
			S_DEL_RD, S_TK_RD: begin
				if (idx_q != cnt_q) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = idx_q[IDX_W-1:0];
				end
			end
			S_DEL_EV: begin
				// entries behind the removed one close the gap
				if (found_q) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = idx_m1[IDX_W-1:0];
					mreq.wr_data = rdata;
				end
			end
			S_TK_EV: begin
				if (tk_expired) begin
					// the previous expired handle now knows it is not the last
					if (pend_q && out_free) begin
						push      = 1'b1;
						push_h    = pend_h_q;
						push_st   = ST_EXPIRED;
						push_last = 1'b0;
					end
				end else if (k_q != '0) begin
					// survivors move to the front past the expired ones
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = IDX_W'(idx_q - k_q);
					mreq.wr_data = rdata;
				end
			end
			S_TK_END: begin
				if (out_free) begin
					push    = 1'b1;
					push_h  = pend_q ? pend_h_q : handle_t'(0);
					push_st = pend_q ? ST_EXPIRED : ST_NONE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					push    = 1'b1;
					push_h  = h_q;
					push_st = status_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			k_q        <= '0;
			found_q    <= 1'b0;
			pend_q     <= 1'b0;
			exp_done_q <= 1'b0;
			cmd_q      <= CMD_ADD;
			status_q   <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q      <= req.command;
						idx_q      <= '0;
						k_q        <= '0;
						found_q    <= 1'b0;
						pend_q     <= 1'b0;
						exp_done_q <= 1'b0;
						unique case (req.command)
							CMD_ADD: begin
								if (cnt_q >= cnt_t'(ENTRIES)) begin
									status_q <= ST_FULL;
									state_q  <= S_RESP;
								end else begin
									idx_q   <= cnt_q;
									state_q <= S_INS_RD;
								end
							end
							CMD_ADJUST, CMD_DELETE: state_q <= S_DEL_RD;
							CMD_TICK:               state_q <= S_TK_RD;
							default:                state_q <= S_IDLE;
						endcase
					end
				end
				S_INS_RD: begin
					if (idx_q == '0) begin
						cnt_q    <= cnt_q + cnt_t'(1);
						status_q <= ST_OK;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_INS_EV;
					end
				end
				S_INS_EV: begin
					if (rdata.expiry > t_q) begin
						idx_q   <= idx_m1;
						state_q <= S_INS_RD;
					end else begin
						cnt_q    <= cnt_q + cnt_t'(1);
						status_q <= ST_OK;
						state_q  <= S_RESP;
					end
				end
				S_DEL_RD: begin
					if (idx_q == cnt_q) begin
						if (found_q) begin
							cnt_q <= cnt_q - cnt_t'(1);
							if (cmd_q == CMD_ADJUST) begin
								// reinsert from the back of the shortened queue
								idx_q   <= cnt_q - cnt_t'(1);
								state_q <= S_INS_RD;
							end else begin
								status_q <= ST_OK;
								state_q  <= S_RESP;
							end
						end else begin
							status_q <= ST_NOTFOUND;
							state_q  <= S_RESP;
						end
					end else begin
						state_q <= S_DEL_EV;
					end
				end
				S_DEL_EV: begin
					if (!found_q && (rdata.handle == h_q)) begin
						found_q <= 1'b1;
					end
					idx_q   <= idx_q + cnt_t'(1);
					state_q <= S_DEL_RD;
				end
				S_TK_RD: begin
					state_q <= (idx_q == cnt_q) ? S_TK_END : S_TK_EV;
				end
				S_TK_EV: begin
					if (tk_expired) begin
						// stall here while an expired handle waits and the result register is occupied
						if (!pend_q || out_free) begin
							pend_q   <= 1'b1;
							pend_h_q <= rdata.handle;
							k_q      <= k_q + cnt_t'(1);
							idx_q    <= idx_q + cnt_t'(1);
							state_q  <= S_TK_RD;
						end
					end else if (k_q == '0) begin
						// nothing expired, queue stays as it is
						state_q <= S_TK_END;
					end else begin
						exp_done_q <= 1'b1;
						idx_q      <= idx_q + cnt_t'(1);
						state_q    <= S_TK_RD;
					end
				end
				S_TK_END: begin
					if (out_free) begin
						cnt_q   <= cnt_q - k_q;
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			h_q <= req.handle;
			t_q <= time_t'(req.time_value);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_h_q    <= push_h;
			out_st_q   <= push_st;
			out_last_q <= push_last;
		end
	end

	// checks
	`SETQ_ASSERT_ALWAYS(a_cnt_range, cnt_q <= cnt_t'(ENTRIES), "entry count beyond capacity")
	`SETQ_ASSERT_IMPLY(a_push_free, push, out_free, "result pushed over a held result")
	`SETQ_ASSERT_IMPLY(a_ins_slot, state_q == S_INS_EV, idx_q < cnt_t'(ENTRIES), "insert slot out of range")
	`SETQ_ASSERT_IMPLY(a_tick_limit, state_q == S_TK_RD || state_q == S_TK_EV || state_q == S_TK_END, k_q <= cnt_t'(TICK_LIMIT), "tick expired too many")

endmodule
